/* design/rti_pkg.sv */
// Shared types and constants of the ray-triangle intersection engine.
`default_nettype none
package rti_pkg;

  // Width of the exact determinant, dot products and divider remainders.
  localparam int WW = 104;
  // Quotient bits produced by the divider pipeline.
  localparam int QW = 32;
  // Width of a configuration register index.
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

  localparam logic signed [31:0] RESET_DIR_Z = 32'sd65536;

  localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN = 32'h8000_0000;

  // Divider lanes.
  localparam int LANE_T = 0;
  localparam int LANE_U = 1;
  localparam int LANE_V = 2;

  typedef struct packed {
    logic signed [31:0] vertex0_x;
    logic signed [31:0] vertex0_y;
    logic signed [31:0] vertex0_z;
    logic signed [31:0] vertex1_x;
    logic signed [31:0] vertex1_y;
    logic signed [31:0] vertex1_z;
    logic signed [31:0] vertex2_x;
    logic signed [31:0] vertex2_y;
    logic signed [31:0] vertex2_z;
  } rti_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_distance;
    logic [16:0]        bary_u;
    logic [16:0]        bary_v;
  } rti_out_t;

  // Payload of one divider step: shared divisor, three remainders, the
  // numerator bits still to shift in, and the quotient bits so far.
  typedef struct packed {
    logic                   miss;
    logic                   neg_t;
    logic                   big;
    logic [WW-1:0]          den;
    logic [2:0][WW-1:0]     rem;
    logic [2:0][QW-1:0]     nlo;
    logic [2:0][QW-1:0]     quo;
  } rti_div_t;

endpackage
`default_nettype wire

/* design/rti_div_stage.sv */
// One restoring-division step for the three quotient lanes.
`default_nettype none
module rti_div_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire rti_pkg::rti_div_t stage_i,
  output logic                   valid_o,
  output rti_pkg::rti_div_t      stage_o
);

  localparam int WW = rti_pkg::WW;
  localparam int QW = rti_pkg::QW;

  logic              valid_q;
  rti_pkg::rti_div_t stage_d, stage_q;

  always_comb begin
    logic [WW:0] r2;
    logic        ge;
    stage_d = stage_i;
    for (int k = 0; k < 3; k++) begin
      r2 = {stage_i.rem[k], stage_i.nlo[k][QW-1]};
      ge = (r2 >= {1'b0, stage_i.den});
      if (ge) begin
        r2 = r2 - {1'b0, stage_i.den};
      end
      stage_d.rem[k] = r2[WW-1:0];
      stage_d.nlo[k] = {stage_i.nlo[k][QW-2:0], 1'b0};
      stage_d.quo[k] = {stage_i.quo[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

/* design/ray_triangle_intersection.sv */
// Top level of the pipelined ray-triangle intersection engine.
// The engine tests one triangle per cycle against a ray held in six
// configuration registers, using the Moller-Trumbore test in exact fixed
// point, and returns one result per triangle in order. A new transfer can be
// accepted on every cycle while the output is not stalled. Eight arithmetic
// stages build the edges, the cross products, the split dot products, the
// sign folding and the hit checks, then 32 divider steps produce one
// quotient bit each for t, u and v, and a final register saturates and
// formats the result. A stall on the output freezes the whole pipeline, so
// nothing is lost or repeated.
// The ray may only be reconfigured while the pipeline is empty. A miss,
// including a zero determinant, reports hit low with all other fields zero.
`default_nettype none
module ray_triangle_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rti_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire rti_pkg::rti_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output rti_pkg::rti_out_t                    out_data_o
);

  localparam int WW  = rti_pkg::WW;
  localparam int QW  = rti_pkg::QW;
  localparam int NW  = WW + FRAC_BITS;
  localparam int TSH = QW - FRAC_BITS;

  // Dot products computed in the middle stages.
  localparam int DOT_DET = 0;
  localparam int DOT_U   = 1;
  localparam int DOT_V   = 2;
  localparam int DOT_T   = 3;

  // ---------------------------------------------------------------------
  // Ray registers. The user must let writes land only while the pipeline
  // is empty; the block does not enforce this. The stages read them directly.
  // ---------------------------------------------------------------------
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [32:0] dir33 [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= rti_pkg::RESET_DIR_Z;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rti_pkg::CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        rti_pkg::CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        rti_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        rti_pkg::CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        rti_pkg::CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        rti_pkg::CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir33[i] = 33'(dir_q[i]);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Every stage advances together whenever the output
  // register is empty or its transfer completes this cycle.
  // ---------------------------------------------------------------------
  logic       en;
  logic       out_valid_q;
  logic [7:0] vld_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: edges e0 = v1 - v0, e1 = v2 - v0 and the unfolded origin
  // offset s = orig - v0. The determinant sign is applied later.
  // ---------------------------------------------------------------------
  logic signed [31:0] v0 [3];
  logic signed [31:0] v1 [3];
  logic signed [31:0] v2 [3];
  logic signed [32:0] e0_1_q [3];
  logic signed [32:0] e1_1_q [3];
  logic signed [32:0] s_1_q  [3];

  assign v0[0] = in_data_i.vertex0_x;
  assign v0[1] = in_data_i.vertex0_y;
  assign v0[2] = in_data_i.vertex0_z;
  assign v1[0] = in_data_i.vertex1_x;
  assign v1[1] = in_data_i.vertex1_y;
  assign v1[2] = in_data_i.vertex1_z;
  assign v2[0] = in_data_i.vertex2_x;
  assign v2[1] = in_data_i.vertex2_y;
  assign v2[2] = in_data_i.vertex2_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0_1_q[i] <= 33'(v1[i]) - 33'(v0[i]);
        e1_1_q[i] <= 33'(v2[i]) - 33'(v0[i]);
        s_1_q[i]  <= 33'(org_q[i]) - 33'(v0[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2 and 3: the three cross products p = dir x e1, q = s x e0 and
  // n = e0 x e1. Stage 2 holds the 18 products, stage 3 the differences.
  // ---------------------------------------------------------------------
  logic signed [65:0] pa_q [3];
  logic signed [65:0] pb_q [3];
  logic signed [65:0] qa_q [3];
  logic signed [65:0] qb_q [3];
  logic signed [65:0] na_q [3];
  logic signed [65:0] nb_q [3];
  logic signed [32:0] e0_2_q [3];
  logic signed [32:0] s_2_q  [3];
  logic signed [66:0] p_3_q [3];
  logic signed [66:0] q_3_q [3];
  logic signed [66:0] n_3_q [3];
  logic signed [32:0] e0_3_q [3];
  logic signed [32:0] s_3_q  [3];

  for (genvar g = 0; g < 3; g++) begin : g_cross
    localparam int G1 = (g + 1) % 3;
    localparam int G2 = (g + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[g]   <= dir33[G1] * e1_1_q[G2];
        pb_q[g]   <= dir33[G2] * e1_1_q[G1];
        qa_q[g]   <= s_1_q[G1] * e0_1_q[G2];
        qb_q[g]   <= s_1_q[G2] * e0_1_q[G1];
        na_q[g]   <= e0_1_q[G1] * e1_1_q[G2];
        nb_q[g]   <= e0_1_q[G2] * e1_1_q[G1];
        e0_2_q[g] <= e0_1_q[g];
        s_2_q[g]  <= s_1_q[g];

        p_3_q[g]  <= 67'(pa_q[g]) - 67'(pb_q[g]);
        q_3_q[g]  <= 67'(qa_q[g]) - 67'(qb_q[g]);
        n_3_q[g]  <= 67'(na_q[g]) - 67'(nb_q[g]);
        e0_3_q[g] <= e0_2_q[g];
        s_3_q[g]  <= s_2_q[g];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4 to 6: the four dot products det = e0.p, u = s.p, v = dir.q
  // and t = n.s. The 67-bit operand is split into an unsigned low part of
  // 34 bits and a signed high part so each multiplier stays near 33 bits.
  // Stage 4 holds the partial products, stage 5 the two partial sums and
  // stage 6 the recombined exact value.
  // ---------------------------------------------------------------------
  logic signed [32:0] a_op [4][3];
  logic signed [66:0] b_op [4][3];
  logic signed [67:0] lo_q [4][3];
  logic signed [65:0] hi_q [4][3];
  logic signed [69:0] losum_q [4];
  logic signed [67:0] hisum_q [4];
  logic signed [WW-1:0] dot_q [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_op[DOT_DET][i] = e0_3_q[i];
      b_op[DOT_DET][i] = p_3_q[i];
      a_op[DOT_U][i]   = s_3_q[i];
      b_op[DOT_U][i]   = p_3_q[i];
      a_op[DOT_V][i]   = dir33[i];
      b_op[DOT_V][i]   = q_3_q[i];
      a_op[DOT_T][i]   = s_3_q[i];
      b_op[DOT_T][i]   = n_3_q[i];
    end
  end

  for (genvar d = 0; d < 4; d++) begin : g_dot
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          lo_q[d][i] <= a_op[d][i] * $signed({1'b0, b_op[d][i][33:0]});
          hi_q[d][i] <= a_op[d][i] * $signed(b_op[d][i][66:34]);
        end
        losum_q[d] <= 70'(lo_q[d][0]) + 70'(lo_q[d][1]) + 70'(lo_q[d][2]);
        hisum_q[d] <= 68'(hi_q[d][0]) + 68'(hi_q[d][1]) + 68'(hi_q[d][2]);
        dot_q[d]   <= (WW'(hisum_q[d]) <<< 34) + WW'(losum_q[d]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: sign folding. A negative determinant negates the determinant,
  // u and v, and flips the sign of t. t is kept as a magnitude plus
  // the sign of the folded value.
  // ---------------------------------------------------------------------
  logic                 neg_det;
  logic signed [WW-1:0] det_7_q;
  logic signed [WW-1:0] u_7_q;
  logic signed [WW-1:0] v_7_q;
  logic [WW-1:0]        tmag_7_q;
  logic                 negt_7_q;

  assign neg_det = dot_q[DOT_DET][WW-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_7_q  <= neg_det ? -dot_q[DOT_DET] : dot_q[DOT_DET];
      u_7_q    <= neg_det ? -dot_q[DOT_U] : dot_q[DOT_U];
      v_7_q    <= neg_det ? -dot_q[DOT_V] : dot_q[DOT_V];
      tmag_7_q <= dot_q[DOT_T][WW-1] ? WW'(-dot_q[DOT_T]) : WW'(dot_q[DOT_T]);
      negt_7_q <= (dot_q[DOT_T] != '0) && (dot_q[DOT_T][WW-1] ^ neg_det);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: hit checks and loading of the divider. Each numerator is the
  // magnitude scaled by 2^FRAC_BITS; its bits above the low 32 form the
  // starting remainder, which is below the divisor whenever the quotient
  // fits in 32 bits. For t that is checked here and flagged as big.
  // ---------------------------------------------------------------------
  logic                 miss_8;
  logic                 big_8;
  logic signed [WW:0]   uv_sum;
  logic [NW-1:0]        num [3];
  rti_pkg::rti_div_t    div0_d;
  rti_pkg::rti_div_t    div0_q;
  rti_pkg::rti_div_t    div_s [QW+1];
  logic                 div_vld [QW+1];

  assign uv_sum = (WW+1)'(u_7_q) + (WW+1)'(v_7_q);
  assign miss_8 = (det_7_q == '0) || u_7_q[WW-1] || v_7_q[WW-1] ||
                  (u_7_q > det_7_q) || (uv_sum > (WW+1)'(det_7_q));
  assign big_8  = (tmag_7_q >> TSH) >= WW'($unsigned(det_7_q));

  assign num[rti_pkg::LANE_T] = {tmag_7_q, {FRAC_BITS{1'b0}}};
  assign num[rti_pkg::LANE_U] = {WW'($unsigned(u_7_q)), {FRAC_BITS{1'b0}}};
  assign num[rti_pkg::LANE_V] = {WW'($unsigned(v_7_q)), {FRAC_BITS{1'b0}}};

  always_comb begin
    div0_d.miss  = miss_8;
    div0_d.neg_t = negt_7_q;
    div0_d.big   = big_8;
    div0_d.den   = WW'($unsigned(det_7_q));
    for (int k = 0; k < 3; k++) begin
      div0_d.rem[k] = WW'(num[k][NW-1:QW]);
      div0_d.nlo[k] = num[k][QW-1:0];
      div0_d.quo[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div0_q <= div0_d;
    end
  end

  assign div_s[0]   = div0_q;
  assign div_vld[0] = vld_q[7];

  // ---------------------------------------------------------------------
  // Stages 9 to 40: one quotient bit per stage for all three lanes.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    rti_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_vld[k]),
      .stage_i (div_s[k]),
      .valid_o (div_vld[k+1]),
      .stage_o (div_s[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: saturation of t, masking of u and v, zero on a miss.
  // ---------------------------------------------------------------------
  rti_pkg::rti_out_t out_d;
  rti_pkg::rti_out_t out_data_q;
  logic [QW-1:0]     tq;

  assign tq = div_s[QW].quo[rti_pkg::LANE_T];

  always_comb begin
    out_d = '0;
    if (!div_s[QW].miss) begin
      out_d.hit    = 1'b1;
      out_d.bary_u = div_s[QW].quo[rti_pkg::LANE_U][16:0];
      out_d.bary_v = div_s[QW].quo[rti_pkg::LANE_V][16:0];
      if (!div_s[QW].neg_t) begin
        out_d.t_distance = (div_s[QW].big || tq[QW-1]) ? rti_pkg::T_MAX : tq;
      end else begin
        out_d.t_distance = (div_s[QW].big || (tq > rti_pkg::T_MIN)) ?
                           rti_pkg::T_MIN : (-tq);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

/* verif/rti_checker.sv */
// Checker that predicts and compares the ray-triangle intersection results.
`timescale 1ns / 100ps
module rti_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  rti_pkg::rti_in_t            in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  rti_pkg::rti_out_t           out_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          hit_count_o
);

  typedef logic signed [127:0] w_t;

  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  rti_pkg::rti_out_t expected_results [$];

  assign pending_o = expected_results.size();

  function automatic void cross3(input w_t a [3], input w_t b [3], output w_t r [3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic w_t dot(input w_t a [3], input w_t b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic rti_pkg::rti_out_t predict(input rti_pkg::rti_in_t tri_in);
    w_t v0 [3], e0 [3], e1 [3], o [3], d [3], p [3], s [3], q [3], n [3];
    w_t det, u, v, t, tq, mag;
    rti_pkg::rti_out_t r;
    r = '0;
    v0[0] = tri_in.vertex0_x; v0[1] = tri_in.vertex0_y; v0[2] = tri_in.vertex0_z;
    e0[0] = w_t'(tri_in.vertex1_x) - v0[0];
    e0[1] = w_t'(tri_in.vertex1_y) - v0[1];
    e0[2] = w_t'(tri_in.vertex1_z) - v0[2];
    e1[0] = w_t'(tri_in.vertex2_x) - v0[0];
    e1[1] = w_t'(tri_in.vertex2_y) - v0[1];
    e1[2] = w_t'(tri_in.vertex2_z) - v0[2];
    for (int i = 0; i < 3; i++) begin
      o[i] = ray_org[i];
      d[i] = ray_dir[i];
    end
    cross3(d, e1, p);
    det = dot(e0, p);
    if (det == 0) return r;
    for (int i = 0; i < 3; i++) s[i] = (det > 0) ? o[i] - v0[i] : v0[i] - o[i];
    if (det < 0) det = -det;
    u = dot(s, p);
    if (u < 0 || u > det) return r;
    cross3(s, e0, q);
    v = dot(d, q);
    if (v < 0 || u + v > det) return r;
    cross3(e0, e1, n);
    t = dot(n, s);
    // Magnitudes here fit well inside 128 bits, so the quotient is exact.
    mag = (t < 0) ? -t : t;
    tq = (mag <<< 16) / det;
    if (t >= 0) r.t_distance = (tq > 128'sh7FFFFFFF) ? rti_pkg::T_MAX : tq[31:0];
    else r.t_distance = (tq > 128'sh80000000) ? rti_pkg::T_MIN : -tq[31:0];
    r.hit = 1'b1;
    r.bary_u = 17'(((u <<< 16) / det));
    r.bary_v = 17'(((v <<< 16) / det));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rti_pkg::rti_out_t exp_r;
    if (!rst_ni) begin
      ray_org[0] <= '0; ray_org[1] <= '0; ray_org[2] <= '0;
      ray_dir[0] <= '0; ray_dir[1] <= '0; ray_dir[2] <= rti_pkg::RESET_DIR_Z;
      fail_count_o <= 0;
      hit_count_o <= 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_results.push_back(predict(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.hit) hit_count_o <= hit_count_o + 1;
          if (exp_r != out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (exp_r.hit != out_data_i.hit)
              $error("hit expected %0d actual %0d", exp_r.hit, out_data_i.hit);
            if (exp_r.t_distance != out_data_i.t_distance)
              $error("t_distance expected %0d actual %0d",
                     exp_r.t_distance, out_data_i.t_distance);
            if (exp_r.bary_u != out_data_i.bary_u)
              $error("bary_u expected %0d actual %0d", exp_r.bary_u, out_data_i.bary_u);
            if (exp_r.bary_v != out_data_i.bary_v)
              $error("bary_v expected %0d actual %0d", exp_r.bary_v, out_data_i.bary_v);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rti_pkg::CFG_ORIGIN_X: ray_org[0] <= cfg_data_i;
          rti_pkg::CFG_ORIGIN_Y: ray_org[1] <= cfg_data_i;
          rti_pkg::CFG_ORIGIN_Z: ray_org[2] <= cfg_data_i;
          rti_pkg::CFG_DIR_X:    ray_dir[0] <= cfg_data_i;
          rti_pkg::CFG_DIR_Y:    ray_dir[1] <= cfg_data_i;
          rti_pkg::CFG_DIR_Z:    ray_dir[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

/* verif/tb_top.sv */
// Top of the testbench: clock, reset, stimulus, ray setup and the verdict.
`timescale 1ns / 100ps
module tb_top;

  // Margin left after the last result has come back.
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rti_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rti_pkg::rti_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rti_pkg::rti_out_t out_data_o;
  int fail_count, pending, hit_count;
  int cycle_count = 0;
  int sent = 0;
  logic out_stall_on = 1'b1;

  always #6 clk_i = ~clk_i;

  ray_triangle_intersection DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  rti_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .hit_count_o(hit_count)
  );

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Gap lengths are mostly short, with the odd long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiver stalls at random; whole stretches run with no stall at all.
  always @(posedge clk_i) begin
    int g;
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) out_stall_on <= ~out_stall_on;
      g = out_stall_on ? gap_len() : 0;
      out_ready_i <= (g == 0);
    end
  end

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // One triangle transfer; valid holds with the payload until accepted.
  // Valid is lowered only in front of a gap, so back-to-back transfers
  // keep it high.
  task automatic send_tri(input rti_pkg::rti_in_t tri_in);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= tri_in;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // Stops sending, then waits until every expected result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    wait_idle();
    write_reg(rti_pkg::CFG_ORIGIN_X, ox);
    write_reg(rti_pkg::CFG_ORIGIN_Y, oy);
    write_reg(rti_pkg::CFG_ORIGIN_Z, oz);
    write_reg(rti_pkg::CFG_DIR_X, dx);
    write_reg(rti_pkg::CFG_DIR_Y, dy);
    write_reg(rti_pkg::CFG_DIR_Z, dz);
    // An index past the last register must be ignored.
    write_reg(rti_pkg::CFG_IDX_W'(6), $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A triangle with all nine coordinates drawn at random in the given mode.
  function automatic rti_pkg::rti_in_t aimed_tri(input int mode);
    rti_pkg::rti_in_t t;
    t.vertex0_x = rand_coord(mode);
    t.vertex0_y = rand_coord(mode);
    t.vertex0_z = rand_coord(mode);
    t.vertex1_x = rand_coord(mode);
    t.vertex1_y = rand_coord(mode);
    t.vertex1_z = rand_coord(mode);
    t.vertex2_x = rand_coord(mode);
    t.vertex2_y = rand_coord(mode);
    t.vertex2_z = rand_coord(mode);
    return t;
  endfunction

  function automatic rti_pkg::rti_in_t mk_tri(input logic [31:0] a, b, c, d, e, f, g, h, i);
    rti_pkg::rti_in_t t;
    t = {a, b, c, d, e, f, g, h, i};
    return t;
  endfunction

  task automatic random_phase(input int count, input int mode);
    for (int k = 0; k < count; k++) send_tri(aimed_tri(($urandom_range(0, 9) == 0) ? 0 : mode));
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset ray: origin at zero looking along +z.
    // Clean hit in front, with the winding flipped for a negative determinant.
    send_tri(mk_tri(MONE, MONE, ONE, ONE, MONE, ONE, 0, ONE, ONE));
    send_tri(mk_tri(MONE, MONE, ONE, 0, ONE, ONE, ONE, MONE, ONE));
    // Hit behind the origin gives a negative t.
    send_tri(mk_tri(MONE, MONE, MONE, ONE, MONE, MONE, 0, ONE, MONE));
    // Degenerate triangle: zero determinant.
    send_tri(mk_tri(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
    // Misses on each barycentric bound.
    send_tri(mk_tri(ONE, ONE, ONE, 32'h0003_0000, ONE, ONE, ONE, 32'h0003_0000, ONE));
    send_tri(mk_tri(MONE, MONE, ONE, 32'hFFFF_8000, MONE, ONE, MONE, 32'hFFFF_8000, ONE));
    // Vertex exactly on the ray: u and v at their extremes.
    send_tri(mk_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
    send_tri(mk_tri(MONE, 0, ONE, 0, 0, ONE, 0, ONE, ONE));
    // Tiny triangle far away: saturates t.
    send_tri(mk_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, SMAX, 1, 32'hFFFF_FFFF, SMAX, 0, 1, SMAX));
    send_tri(mk_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, SMIN, 1, 32'hFFFF_FFFF, SMIN, 0, 1, SMIN));
    // Field extremes.
    send_tri(mk_tri(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMAX, SMIN));
    send_tri(mk_tri(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMAX, SMIN));
    send_tri(mk_tri('1, '1, '1, 0, 0, 0, SMAX, SMIN, 0));

    // The sender holds off until the pipeline has drained.
    wait_idle();

    // Extreme ray settings, then random ones.
    set_ray(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
    random_phase(30, 0);
    set_ray(0, 0, 0, ONE, ONE, ONE);
    random_phase(100, 1);
    set_ray(0, 0, 0, 0, 0, 0);
    random_phase(20, 1);
    for (int ph = 0; ph < 6; ph++) begin
      set_ray(rand_coord(1), rand_coord(1), rand_coord(1),
              rand_coord(1), rand_coord(1), rand_coord(1));
      random_phase(70, 1 + ph % 2);
      set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase(30, 0);
    end

    wait_idle();
    $display("tb_top: %0d triangles over several ray settings, %0d hits seen.", sent, hit_count);
    $display("tb_top: covered zero determinant, both windings, misses, saturation, extremes.");
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
